// ===== rtl/zpmv_pkg.sv =====
package zpmv_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int COUNT_W         = 9;

  typedef enum logic [1:0] {
    REG_ZERO_POINT = 2'd0,
    REG_ROWS       = 2'd1,
    REG_COLUMNS    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [7:0]    zero_point;
    logic [COUNT_W-1:0]   rows_in_use;
    logic [COUNT_W-1:0]   columns_in_use;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic signed [7:0] weight;
    logic              end_row;
    logic [7:0]        row_num;
    logic              last;
  } ctl_t;

endpackage

// ===== rtl/zpmv_in_if.sv =====
interface zpmv_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  logic signed [7:0] value;
  logic [7:0]        vector_index;

  modport source (output valid, output mode, output value, output vector_index, input ready);
  modport sink (input valid, input mode, input value, input vector_index, output ready);
endinterface

// ===== rtl/zpmv_out_if.sv =====
interface zpmv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] row_sum;
  logic [7:0]         row_number;
  logic               last_row;

  modport source (output valid, output row_sum, output row_number, output last_row,
                  input ready);
  modport sink (input valid, input row_sum, input row_number, input last_row,
                output ready);
endinterface

// ===== rtl/zpmv_cfg.sv =====
module zpmv_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [zpmv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [zpmv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [zpmv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output zpmv_pkg::cfg_t                  cfg
);

  logic               wr;
  zpmv_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = zpmv_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_point     <= 8'sd0;
      cfg.rows_in_use    <= zpmv_pkg::COUNT_W'(1);
      cfg.columns_in_use <= zpmv_pkg::COUNT_W'(1);
    end else if (wr) begin
      unique case (idx)
        zpmv_pkg::REG_ZERO_POINT: cfg.zero_point     <= pwdata[7:0];
        zpmv_pkg::REG_ROWS:       cfg.rows_in_use    <= pwdata[zpmv_pkg::COUNT_W-1:0];
        zpmv_pkg::REG_COLUMNS:    cfg.columns_in_use <= pwdata[zpmv_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      zpmv_pkg::REG_ZERO_POINT: prdata = zpmv_pkg::CFG_DATA_W'(unsigned'(cfg.zero_point));
      zpmv_pkg::REG_ROWS:       prdata = zpmv_pkg::CFG_DATA_W'(cfg.rows_in_use);
      zpmv_pkg::REG_COLUMNS:    prdata = zpmv_pkg::CFG_DATA_W'(cfg.columns_in_use);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/zpmv_vec_mem.sv =====
module zpmv_vec_mem #(
  parameter int DEPTH  = zpmv_pkg::MAX_COLUMNS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic signed [7:0] rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/zpmv_seq.sv =====
module zpmv_seq #(
  parameter int MAX_COLUMNS = zpmv_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = zpmv_pkg::MAX_ROWS_DEF,
  parameter int CPOS_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic               mode,
  input  logic signed [7:0]  value,
  input  logic [7:0]         vector_index,
  input  zpmv_pkg::cfg_t     cfg,
  output logic               mem_we,
  output logic [CPOS_W-1:0]  mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic               mem_re,
  output logic [CPOS_W-1:0]  mem_raddr,
  output zpmv_pkg::ctl_t     s1
);

  localparam int RPOS_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W  = $clog2(MAX_COLUMNS + MAX_ROWS + 1024) + 1;

  logic [CPOS_W-1:0] col_pos;
  logic [RPOS_W-1:0] row_pos;
  logic [CMP_W-1:0]  cols_raw;
  logic [CMP_W-1:0]  rows_raw;
  logic [CMP_W-1:0]  cols_c;
  logic [CMP_W-1:0]  rows_c;
  logic              col_end;
  logic              row_end;
  logic              take_w;
  logic              in_range;

  assign cols_raw = CMP_W'(cfg.columns_in_use);
  assign rows_raw = CMP_W'(cfg.rows_in_use);

  always_comb begin
    if (cols_raw == '0) begin
      cols_c = CMP_W'(1);
    end else if (cols_raw > CMP_W'(MAX_COLUMNS)) begin
      cols_c = CMP_W'(MAX_COLUMNS);
    end else begin
      cols_c = cols_raw;
    end
    if (rows_raw == '0) begin
      rows_c = CMP_W'(1);
    end else if (rows_raw > CMP_W'(MAX_ROWS)) begin
      rows_c = CMP_W'(MAX_ROWS);
    end else begin
      rows_c = rows_raw;
    end
  end

  assign col_end  = (CMP_W'(col_pos) + CMP_W'(1)) >= cols_c;
  assign row_end  = (CMP_W'(row_pos) + CMP_W'(1)) >= rows_c;
  assign take_w   = adv && in_valid && mode;
  assign in_range = 32'(vector_index) < 32'(MAX_COLUMNS);

  assign mem_we    = adv && in_valid && !mode && in_range;
  assign mem_waddr = CPOS_W'(vector_index);
  assign mem_wdata = 8'(value - cfg.zero_point);
  assign mem_re    = adv;
  assign mem_raddr = col_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (take_w) begin
      if (!col_end) begin
        col_pos <= col_pos + CPOS_W'(1);
      end else begin
        col_pos <= '0;
        row_pos <= row_end ? '0 : row_pos + RPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (adv) begin
      s1.valid   <= in_valid && mode;
      s1.weight  <= value;
      s1.end_row <= col_end;
      s1.row_num <= 8'(row_pos);
      s1.last    <= row_end;
    end
  end

endmodule

// ===== rtl/zpmv_mac.sv =====
module zpmv_mac (
  input  logic               clk,
  input  logic               rst,
  input  zpmv_pkg::ctl_t     s1,
  input  logic signed [7:0]  rdata,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] row_sum,
  output logic [7:0]         row_number,
  output logic               last_row
);

  zpmv_pkg::ctl_t     s2;
  logic signed [15:0] prod;
  logic signed [15:0] acc;
  logic signed [15:0] sum;
  logic               emit;

  assign adv  = !(s2.valid && s2.end_row && out_valid && !out_ready);
  assign sum  = acc + prod;
  assign emit = adv && s2.valid && s2.end_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (adv) begin
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= s1.weight * rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv && s2.valid) begin
      acc <= s2.end_row ? 16'sd0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      row_sum    <= sum;
      row_number <= s2.row_num;
      last_row   <= s2.last;
    end
  end

endmodule

// ===== rtl/int8_zero_point_matvec_core.sv =====
// Channel   Role    Handshake     Carries
// in_ch     sink    valid/ready   mode, value, vector_index
// out_ch    source  valid/ready   row_sum, row_number, last_row
// apb       slave   psel/penable  zero_point, rows_in_use, columns_in_use
//
// One item per cycle while in_ch.ready is high, vector writes and weights alike; a row's
// sum leaves after its final weight transfer via vector read, multiply and accumulate.
// Synchronous reset clears positions, accumulator and valids; the vector memory
// is not cleared and holds garbage until written.
// in_ch.ready drops only while a row's final sum sits at the accumulator and the
// previous sum is still waiting in the output register.
module int8_zero_point_matvec_core #(
  parameter int MAX_COLUMNS = zpmv_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = zpmv_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  zpmv_in_if.sink                         in_ch,
  zpmv_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [zpmv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [zpmv_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [zpmv_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CPOS_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  zpmv_pkg::cfg_t     cfg;
  zpmv_pkg::ctl_t     s1;
  logic               adv;
  logic               mem_we;
  logic [CPOS_W-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic               mem_re;
  logic [CPOS_W-1:0]  mem_raddr;
  logic signed [7:0]  mem_rdata;

  assign in_ch.ready = adv;

  zpmv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  zpmv_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CPOS_W      (CPOS_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_ch.valid),
    .mode         (in_ch.mode),
    .value        (in_ch.value),
    .vector_index (in_ch.vector_index),
    .cfg          (cfg),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .s1           (s1)
  );

  zpmv_vec_mem #(
    .DEPTH  (MAX_COLUMNS),
    .ADDR_W (CPOS_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  zpmv_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .s1         (s1),
    .rdata      (mem_rdata),
    .adv        (adv),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .row_sum    (out_ch.row_sum),
    .row_number (out_ch.row_number),
    .last_row   (out_ch.last_row)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!in_ch.ready && !out_ch.ready) |=> out_ch.valid)
    else $error("pending result lost during stall");

endmodule

// ===== test/zpmv_row_sum_checker.sv =====
`timescale 1ns / 100ps

module zpmv_row_sum_checker (
  input  logic                            clk,
  input  logic                            rst,
  zpmv_in_if                              in_ch,
  zpmv_out_if                             out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [zpmv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [zpmv_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic signed [15:0] row_sum;
    logic [7:0]         row_number;
    logic               last_row;
  } row_result_t;

  row_result_t                  sums_due[$];
  logic signed [7:0]            centered[zpmv_pkg::MAX_COLUMNS_DEF];
  logic signed [7:0]            zero_point;
  logic [zpmv_pkg::COUNT_W-1:0] rows_cfg;
  logic [zpmv_pkg::COUNT_W-1:0] cols_cfg;
  logic [15:0]                  acc;
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int                           errs = 0;

  function automatic int unsigned span(input logic [zpmv_pkg::COUNT_W-1:0] n,
                                       input int unsigned limit);
    if (n == 0) return 1;
    return (n > limit) ? limit : n;
  endfunction

  task automatic take_item(input logic is_weight, input logic signed [7:0] v,
                           input logic [7:0] idx);
    row_result_t        r;
    logic signed [15:0] prod;
    if (!is_weight) begin
      centered[idx] = v - zero_point;
      return;
    end
    prod = v * centered[col_pos];
    acc = acc + prod;
    if (col_pos + 1 < span(cols_cfg, zpmv_pkg::MAX_COLUMNS_DEF)) begin
      col_pos++;
    end else begin
      r.row_sum    = acc;
      r.row_number = row_pos[7:0];
      r.last_row   = (row_pos + 1 >= span(rows_cfg, zpmv_pkg::MAX_ROWS_DEF));
      sums_due.push_back(r);
      acc     = '0;
      col_pos = 0;
      row_pos = r.last_row ? 0 : row_pos + 1;
    end
  endtask

  task automatic match_sum;
    row_result_t e;
    if (sums_due.size() == 0) begin
      errs++;
      $display("%0t: unexpected transfer, expected none, got sum %0d row %0d last %0d",
               $time, out_ch.row_sum, out_ch.row_number, out_ch.last_row);
      return;
    end
    e = sums_due.pop_front();
    if (out_ch.row_sum !== e.row_sum) begin
      errs++;
      $display("%0t: row_sum expected %0d got %0d", $time, e.row_sum, out_ch.row_sum);
    end
    if (out_ch.row_number !== e.row_number) begin
      errs++;
      $display("%0t: row_number expected %0d got %0d", $time, e.row_number,
               out_ch.row_number);
    end
    if (out_ch.last_row !== e.last_row) begin
      errs++;
      $display("%0t: last_row expected %0d got %0d", $time, e.last_row, out_ch.last_row);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sums_due.delete();
      zero_point = '0;
      rows_cfg   = 1;
      cols_cfg   = 1;
      acc        = '0;
      col_pos    = 0;
      row_pos    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[zpmv_pkg::CFG_ADDR_W-1:2])
          zpmv_pkg::REG_ZERO_POINT: zero_point = pwdata[7:0];
          zpmv_pkg::REG_ROWS:       rows_cfg   = pwdata[zpmv_pkg::COUNT_W-1:0];
          zpmv_pkg::REG_COLUMNS:    cols_cfg   = pwdata[zpmv_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) match_sum();
      if (in_ch.valid && in_ch.ready) take_item(in_ch.mode, in_ch.value, in_ch.vector_index);
    end
    outstanding <= sums_due.size();
    mismatches  <= errs;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic       MODE_VECTOR = 1'b0;
  localparam logic       MODE_WEIGHT = 1'b1;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [zpmv_pkg::CFG_ADDR_W-1:0] paddr;
  logic [zpmv_pkg::CFG_DATA_W-1:0] pwdata;
  logic [zpmv_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int         mismatches;
  int         outstanding;
  bit         idle_on;
  bit         long_hold;
  bit         hold_taken;
  bit [255:0] written;
  int         reach;
  int         items_sent;
  int         stall_left;
  int         p;

  zpmv_in_if  in_ch();
  zpmv_out_if out_ch();

  int8_zero_point_matvec_core u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  zpmv_row_sum_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (long_hold && !hold_taken) begin
          stall_left = 300;
          hold_taken = 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 14);
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int count_of(input logic [zpmv_pkg::COUNT_W-1:0] n, input int limit);
    if (n == 0) return 1;
    return (n > limit) ? limit : n;
  endfunction

  task automatic send_transfer(input logic m, input logic signed [7:0] v,
                               input logic [7:0] idx);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.value        <= v;
    in_ch.vector_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic load_element(input logic [7:0] idx, input logic signed [7:0] v);
    send_transfer(MODE_VECTOR, v, idx);
    written[idx] = 1'b1;
  endtask

  task automatic push_weight(input logic signed [7:0] w);
    send_transfer(MODE_WEIGHT, w, 8'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [zpmv_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic signed [7:0] zp,
                            input logic [zpmv_pkg::COUNT_W-1:0] rows,
                            input logic [zpmv_pkg::COUNT_W-1:0] cols);
    write_reg(zpmv_pkg::REG_ZERO_POINT, {{24{zp[7]}}, zp});
    write_reg(zpmv_pkg::REG_ROWS, 32'(rows));
    write_reg(zpmv_pkg::REG_COLUMNS, 32'(cols));
  endtask

  // drop valid, let every row sum come out, then let the pipeline settle
  task automatic wait_quiet;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    logic signed [7:0]            zp;
    logic [zpmv_pkg::COUNT_W-1:0] rows;
    logic [zpmv_pkg::COUNT_W-1:0] cols;
    int                           rows_n;
    int                           cols_n;
    int                           total;
    int                           i;
    bit                           special;
    case ($urandom_range(0, 5))
      0:       zp = -8'sd128;
      1:       zp = 8'sd127;
      default: zp = 8'($urandom);
    endcase
    rows = zpmv_pkg::COUNT_W'($urandom_range(0, 6));
    cols = zpmv_pkg::COUNT_W'($urandom_range(0, 8));
    special = 1'b1;
    if (n == 1) begin
      rows = 9'd64;
      cols = 9'd1;
    end else if (n == 6) begin
      rows = 9'd1;
      cols = 9'h1FF;
    end else if (n == 10) begin
      rows = 9'd300;
      cols = 9'd1;
    end else begin
      special = 1'b0;
    end
    set_config(zp, rows, cols);
    rows_n = count_of(rows, zpmv_pkg::MAX_ROWS_DEF);
    cols_n = count_of(cols, zpmv_pkg::MAX_COLUMNS_DEF);
    if (cols_n > reach) reach = cols_n;
    for (i = 0; i < reach; i++) begin
      if (!written[i]) load_element(8'(i), 8'($urandom));
    end
    total = rows_n * cols_n;
    if (!special && $urandom_range(0, 4) == 0) total = $urandom_range(1, total);
    if (n == 1) long_hold = 1'b1;
    while (total > 0) begin
      if ($urandom_range(0, 5) == 0) begin
        load_element(8'($urandom), 8'($urandom));
      end else begin
        push_weight(8'($urandom));
        total--;
      end
    end
    wait_quiet();
  endtask

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_VECTOR;
    in_ch.value        <= '0;
    in_ch.vector_index <= '0;
    idle_on    = 1'b1;
    long_hold  = 1'b0;
    written    = '0;
    reach      = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(-8'sd128, 9'd2, 9'd4);
    load_element(8'd0, 8'sd127);
    load_element(8'd1, -8'sd128);
    load_element(8'd2, 8'sd0);
    load_element(8'd3, -8'sd1);
    load_element(8'd255, 8'sd55);
    push_weight(-8'sd128);
    push_weight(8'sd127);
    push_weight(-8'sd128);
    push_weight(8'sd1);
    push_weight(8'sd127);
    push_weight(-8'sd128);
    push_weight(8'sd127);
    push_weight(-8'sd128);
    wait_quiet();

    // stored elements keep the old zero point
    set_config(8'sd127, 9'd2, 9'd4);
    load_element(8'd0, -8'sd128);
    push_weight(-8'sd128);
    push_weight(8'sd127);
    wait_quiet();

    // shrink the row below the running column
    set_config(8'sd127, 9'd2, 9'd2);
    push_weight(8'sd1);
    wait_quiet();

    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    set_config(8'sd0, 9'd0, 9'd0);
    push_weight(8'sd127);
    push_weight(-8'sd1);
    wait_quiet();

    reach = 4;
    items_sent = 0;
    p = 0;
    while (p <= 10 || items_sent < 500) begin
      run_phase(p);
      p++;
    end
    idle_on = 1'b0;
    repeat (4) begin
      run_phase(p);
      p++;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
